[hdl/tacm_pkg.sv]
// Package for the touch auto-range coordinate mapper.
// Holds the field widths, reset constants, register indexes, controller states and command/status
// structs. No dependencies.
package tacm_pkg;

  localparam int COORD_W = 12;
  localparam int RAW_W = 12;
  localparam int PROD_W = 2 * COORD_W;
  localparam int CNT_W = $clog2(COORD_W);

  // Converter resolution. Raw readings are masked to this many bits.
  localparam int ADC_BITS = 12;
  localparam logic [RAW_W-1:0] RAW_MASK =
    (ADC_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << ADC_BITS) - 1);

  // Reset values of the bounds and the screen size.
  localparam logic [COORD_W-1:0] MIN_X_RST = COORD_W'(200);
  localparam logic [COORD_W-1:0] MAX_X_RST = COORD_W'(3700);
  localparam logic [COORD_W-1:0] MIN_Y_RST = COORD_W'(240);
  localparam logic [COORD_W-1:0] MAX_Y_RST = COORD_W'(3800);
  localparam logic [COORD_W-1:0] WIDTH_RST = COORD_W'(320);
  localparam logic [COORD_W-1:0] HEIGHT_RST = COORD_W'(240);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_DIVIDE,
    ST_FINISH,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic capture;    // latch the input beat
    logic update;     // widen the bounds
    logic start_div;  // multiply and load both divider lanes
    logic div_step;   // one quotient bit per lane
    logic finish;     // form the held coordinates
    logic load_out;   // move held values into the output register
  } cmd_t;

  typedef struct packed {
    logic touched;    // latched touched flag
    logic out_free;   // output register can take a beat this cycle
  } status_t;

endpackage

[hdl/tacm_div.sv]
// One restoring divider lane: 24-bit dividend by 12-bit divisor, one quotient bit per step.
// Quotient must fit in 12 bits (upper dividend half below the divisor). Uses tacm_pkg.
module tacm_div (
  input  logic                            clk,
  input  logic                            load,
  input  logic                            step,
  input  logic [tacm_pkg::PROD_W-1:0]     dividend,
  input  logic [tacm_pkg::COORD_W-1:0]    divisor,
  output logic [tacm_pkg::COORD_W-1:0]    quotient
);

  logic [tacm_pkg::COORD_W-1:0] rem;
  logic [tacm_pkg::COORD_W-1:0] acc;
  logic [tacm_pkg::COORD_W-1:0] divisor_q;
  logic [tacm_pkg::COORD_W:0]   shifted;
  logic [tacm_pkg::COORD_W:0]   trial;

  assign shifted = {rem, acc[tacm_pkg::COORD_W-1]};
  assign trial = shifted - {1'b0, divisor_q};

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= dividend[tacm_pkg::PROD_W-1:tacm_pkg::COORD_W];
      acc <= dividend[tacm_pkg::COORD_W-1:0];
      divisor_q <= divisor;
    end else if (step) begin
      // remainder stays below the divisor, so the shifted value fits the field
      if (!trial[tacm_pkg::COORD_W]) begin
        rem <= trial[tacm_pkg::COORD_W-1:0];
      end else begin
        rem <= shifted[tacm_pkg::COORD_W-1:0];
      end
      acc <= {acc[tacm_pkg::COORD_W-2:0], ~trial[tacm_pkg::COORD_W]};
    end
  end

  assign quotient = acc;

endmodule

[hdl/tacm_dpath.sv]
// Datapath: input latch, bounds, screen size registers, multiply, two divider lanes,
// held coordinates and output register. Uses tacm_pkg and tacm_div.
module tacm_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  tacm_pkg::cmd_t                     cmd,
  output tacm_pkg::status_t                  status,
  input  logic                               touched,
  input  logic [tacm_pkg::RAW_W-1:0]         raw_x,
  input  logic [tacm_pkg::RAW_W-1:0]         raw_y,
  input  logic                               cfg_valid,
  input  logic [tacm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tacm_pkg::COORD_W-1:0]       cfg_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tacm_pkg::COORD_W-1:0]       screen_x,
  output logic [tacm_pkg::COORD_W-1:0]       screen_y,
  output logic                               pressed
);

  logic                            touched_q;
  logic [tacm_pkg::COORD_W-1:0]    rx_q;
  logic [tacm_pkg::COORD_W-1:0]    ry_q;
  logic [tacm_pkg::COORD_W-1:0]    min_x;
  logic [tacm_pkg::COORD_W-1:0]    max_x;
  logic [tacm_pkg::COORD_W-1:0]    min_y;
  logic [tacm_pkg::COORD_W-1:0]    max_y;
  logic [tacm_pkg::COORD_W-1:0]    width;
  logic [tacm_pkg::COORD_W-1:0]    height;
  logic [tacm_pkg::COORD_W-1:0]    held_x;
  logic [tacm_pkg::COORD_W-1:0]    held_y;

  logic [tacm_pkg::COORD_W-1:0]    delta_x;
  logic [tacm_pkg::COORD_W-1:0]    delta_y;
  logic [tacm_pkg::COORD_W-1:0]    span_x;
  logic [tacm_pkg::COORD_W-1:0]    span_y;
  logic [tacm_pkg::COORD_W-1:0]    mag_x;
  logic [tacm_pkg::COORD_W-1:0]    mag_y;
  logic [tacm_pkg::PROD_W-1:0]     prod_x;
  logic [tacm_pkg::PROD_W-1:0]     prod_y;
  logic [tacm_pkg::COORD_W-1:0]    quo_x;
  logic [tacm_pkg::COORD_W-1:0]    quo_y;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      touched_q <= touched;
      rx_q <= raw_x & tacm_pkg::RAW_MASK;
      ry_q <= raw_y & tacm_pkg::RAW_MASK;
    end
  end

  // bounds only widen, so max > min always holds
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= tacm_pkg::MIN_X_RST;
      max_x <= tacm_pkg::MAX_X_RST;
      min_y <= tacm_pkg::MIN_Y_RST;
      max_y <= tacm_pkg::MAX_Y_RST;
    end else if (cmd.update) begin
      if (rx_q < min_x) begin
        min_x <= rx_q;
      end
      if (rx_q > max_x) begin
        max_x <= rx_q;
      end
      if (ry_q < min_y) begin
        min_y <= ry_q;
      end
      if (ry_q > max_y) begin
        max_y <= ry_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= tacm_pkg::WIDTH_RST;
      height <= tacm_pkg::HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tacm_pkg::REG_SCREEN_WIDTH:  width <= cfg_data;
        tacm_pkg::REG_SCREEN_HEIGHT: height <= cfg_data;
        default: ;
      endcase
    end
  end

  // size >= 1: coord = size - delta*(size-1)/span; size 0: coord = delta/span
  assign delta_x = rx_q - min_x;
  assign delta_y = ry_q - min_y;
  assign span_x = max_x - min_x;
  assign span_y = max_y - min_y;
  assign mag_x = (width == '0) ? tacm_pkg::COORD_W'(1) : width - tacm_pkg::COORD_W'(1);
  assign mag_y = (height == '0) ? tacm_pkg::COORD_W'(1) : height - tacm_pkg::COORD_W'(1);
  assign prod_x = tacm_pkg::PROD_W'(delta_x) * tacm_pkg::PROD_W'(mag_x);
  assign prod_y = tacm_pkg::PROD_W'(delta_y) * tacm_pkg::PROD_W'(mag_y);

  tacm_div u_div_x (
    .clk      (clk),
    .load     (cmd.start_div),
    .step     (cmd.div_step),
    .dividend (prod_x),
    .divisor  (span_x),
    .quotient (quo_x)
  );

  tacm_div u_div_y (
    .clk      (clk),
    .load     (cmd.start_div),
    .step     (cmd.div_step),
    .dividend (prod_y),
    .divisor  (span_y),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
    end else if (cmd.finish) begin
      held_x <= (width == '0) ? quo_x : width - quo_x;
      held_y <= (height == '0) ? quo_y : height - quo_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      screen_x <= held_x;
      screen_y <= held_y;
      pressed <= touched_q;
    end
  end

  assign status.touched = touched_q;
  assign status.out_free = !out_valid || !out_stall;

endmodule

[hdl/tacm_ctrl.sv]
// Controller state machine: sequences capture, bound update, multiply, divide and output load.
// Uses tacm_pkg.
module tacm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tacm_pkg::status_t   status,
  output tacm_pkg::cmd_t      cmd
);

  tacm_pkg::state_t              state;
  tacm_pkg::state_t              state_next;
  logic [tacm_pkg::CNT_W-1:0]    step_cnt;
  logic [tacm_pkg::CNT_W-1:0]    step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tacm_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    step_cnt_next = step_cnt;
    unique case (state)
      tacm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tacm_pkg::ST_UPDATE;
        end
      end
      tacm_pkg::ST_UPDATE: begin
        state_next = status.touched ? tacm_pkg::ST_MULT : tacm_pkg::ST_PUSH;
      end
      tacm_pkg::ST_MULT: begin
        state_next = tacm_pkg::ST_DIVIDE;
        step_cnt_next = tacm_pkg::CNT_W'(tacm_pkg::COORD_W - 1);
      end
      tacm_pkg::ST_DIVIDE: begin
        step_cnt_next = step_cnt - tacm_pkg::CNT_W'(1);
        if (step_cnt == '0) begin
          state_next = tacm_pkg::ST_FINISH;
        end
      end
      tacm_pkg::ST_FINISH: begin
        state_next = tacm_pkg::ST_PUSH;
      end
      tacm_pkg::ST_PUSH: begin
        if (status.out_free) begin
          state_next = tacm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tacm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      tacm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      tacm_pkg::ST_UPDATE: cmd.update = status.touched;
      tacm_pkg::ST_MULT:   cmd.start_div = 1'b1;
      tacm_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      tacm_pkg::ST_FINISH: cmd.finish = 1'b1;
      tacm_pkg::ST_PUSH:   cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/touch_autorange_coordinate_mapper.sv]
// Touch auto-range coordinate mapper, top level.
// Sequence: a press beat, once accepted, passes capture, bound update, multiply, 12 restoring
// divide steps, finish and load into the output register; a release beat skips multiply, divide and finish.
// One beat at a time: a new beat is accepted only after the last one is loaded and the FSM is
// back in idle. The 12-step divider lanes (X and Y) run side by side.
// Output register lets the next beat start early; the load waits while a beat still waits there stalled.
// Reset (rst, synchronous): bounds, screen size and held coordinates to defaults, FSM idle.
module touch_autorange_coordinate_mapper (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 touched,
  input  logic [tacm_pkg::RAW_W-1:0]           raw_x,
  input  logic [tacm_pkg::RAW_W-1:0]           raw_y,
  // coordinate channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tacm_pkg::COORD_W-1:0]         screen_x,
  output logic [tacm_pkg::COORD_W-1:0]         screen_y,
  output logic                                 pressed,
  // register write channel: 0 screen_width, 1 screen_height, others ignored
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tacm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tacm_pkg::COORD_W-1:0]         cfg_data
);

  tacm_pkg::cmd_t     cmd;
  tacm_pkg::status_t  status;

  // registers must be written only while idle (the block does not enforce this), so writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer: IDLE -> UPDATE -> (MULT -> DIVIDE x12 -> FINISH) -> PUSH
  tacm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // bounds, mapping arithmetic, held coordinates and output register
  tacm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .touched   (touched),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .pressed   (pressed)
  );

  // one command per cycle at most
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.update, cmd.start_div, cmd.div_step, cmd.finish, cmd.load_out}))
    else $error("more than one datapath command active");

  // an accepted beat is latched and the block goes busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> cmd.capture ##1 in_stall)
    else $error("accepted beat not captured or block not busy");

  // output load never overwrites a beat still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // a load always presents a beat next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded beat not presented");

endmodule
